// ----- sv/fma_pkg.sv -----
// fma_pkg: shared codes, defaults and the cell control bundle for the fit allocator
// used by fma_cell and fit_memory_allocator; no dependencies
package fma_pkg;

  localparam int HOLES_DEF      = 16;
  localparam int SIZE_WIDTH_DEF = 16;

  localparam int OP_W    = 2;
  localparam int SEL_W   = 4;
  localparam int REQ_W   = 16;
  localparam int IDX_OUT_W = 4;
  localparam int REM_OUT_W = 16;
  localparam int MODE_W  = 2;
  localparam int COUNT_W = 5;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REQUEST = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_FIT_MODE   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_HOLE_COUNT = 1'b1;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              load;
    logic              restart;
    logic              commit;
    logic [MODE_W-1:0] mode;
  } cell_ctrl_t;

endpackage

// ----- sv/fma_cell.sv -----
// fma_cell: one hole of the allocator, holding capacity and remaining size
// passes the search token and best candidate so far to its neighbour; uses fma_pkg
module fma_cell
  import fma_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int IW         = 4,
  parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cell_ctrl_t            ctrl,
  input  logic [COUNT_W-1:0]    hole_count,
  input  logic [IW-1:0]         sel_idx,
  input  logic [SIZE_WIDTH-1:0] size,
  input  logic                  tok_i,
  input  logic                  found_i,
  input  logic [IW-1:0]         pidx_i,
  input  logic [SIZE_WIDTH-1:0] prem_i,
  output logic                  tok_o,
  output logic                  found_o,
  output logic [IW-1:0]         pidx_o,
  output logic [SIZE_WIDTH-1:0] prem_o
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [SIZE_WIDTH-1:0] cap_r, rem_r;
  logic                  tok_r, found_r;
  logic [IW-1:0]         pidx_r;
  logic [SIZE_WIDTH-1:0] prem_r;
  logic                  in_use, qual, take, mine;

  assign in_use = (32'(hole_count) > 32'(IDX));
  assign qual   = in_use && (rem_r >= size);
  assign take   = qual && (!found_i
                  || ((ctrl.mode == MODE_BEST)  && (rem_r < prem_i))
                  || ((ctrl.mode == MODE_WORST) && (rem_r > prem_i)));
  assign mine   = (sel_idx == MY_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= '0;
      rem_r   <= '0;
      tok_r   <= 1'b0;
      found_r <= 1'b0;
    end else begin
      if (ctrl.load && mine) begin
        cap_r <= size;
        rem_r <= size;
      end else if (ctrl.restart) begin
        rem_r <= cap_r;
      end else if (ctrl.commit && mine) begin
        rem_r <= rem_r - size;
      end
      tok_r <= tok_i;
      if (tok_i) begin
        found_r <= found_i || take;
      end
    end
  end

  // candidate payload, only meaningful behind the token
  always_ff @(posedge clk) begin
    if (tok_i) begin
      pidx_r <= take ? MY_IDX : pidx_i;
      prem_r <= take ? rem_r : prem_i;
    end
  end

  assign tok_o   = tok_r;
  assign found_o = found_r;
  assign pidx_o  = pidx_r;
  assign prem_o  = prem_r;

endmodule

// ----- sv/fit_memory_allocator.sv -----
// Fit memory allocator: a row of HOLES cells, each holding one hole's capacity and
// remaining size. A load or restart item passes from IDLE through DONE back to IDLE.
// For a request item a search token walks the cell row one cell per clock, carrying
// the best candidate so far; as it leaves the last cell, the request is written back
// into the chosen hole and the result is registered, then DONE moves the result to
// the output register once it is free. One item is worked on at a time; a result
// waiting there does not hold off the next item until that item's result is ready.
// top level; uses fma_pkg and fma_cell
module fit_memory_allocator
  import fma_pkg::*;
#(
  parameter int HOLES      = HOLES_DEF,
  parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // hole_select[3:0], request_size[19:4]
  input  logic [OP_W-1:0]       in_tuser,   // opcode[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // hole_index[3:0], remaining_after[19:4]
  output logic [0:0]            out_tuser   // granted[0]
);

  localparam int IW = (HOLES > 1) ? $clog2(HOLES) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]           st_r, st_nxt;
  logic [MODE_W-1:0]    mode_r;
  logic [COUNT_W-1:0]   count_r;
  logic [SIZE_WIDTH-1:0] size_r, size_nxt;
  logic                 start_r, start_nxt;
  logic                 res_gr_r, res_gr_nxt;
  logic [IDX_OUT_W-1:0] res_idx_r, res_idx_nxt;
  logic [REM_OUT_W-1:0] res_rem_r, res_rem_nxt;
  logic                 ov_r, ov_nxt;
  logic                 og_r, og_nxt;
  logic [IDX_OUT_W-1:0] oidx_r, oidx_nxt;
  logic [REM_OUT_W-1:0] orem_r, orem_nxt;

  logic [OP_W-1:0]       in_op;
  logic [SEL_W-1:0]      in_sel;
  logic [REQ_W-1:0]      in_req;
  logic [31:0]           req_ext, sel_ext, pidx_ext, rem_ext;
  logic [SIZE_WIDTH-1:0] in_size, size_bus, rem_after;
  logic [IW-1:0]         sel_bus;
  logic                  accept, sel_ok, last_tok;
  cell_ctrl_t            ctrl;

  logic                  tok   [0:HOLES];
  logic                  found [0:HOLES];
  logic [IW-1:0]         pidx  [0:HOLES];
  logic [SIZE_WIDTH-1:0] prem  [0:HOLES];

  assign in_op   = in_tuser;
  assign in_sel  = in_tdata[3:0];
  assign in_req  = in_tdata[19:4];
  assign req_ext = 32'(in_req);
  assign in_size = req_ext[SIZE_WIDTH-1:0];
  assign sel_ext = 32'(in_sel);
  assign sel_ok  = (sel_ext < 32'(HOLES));

  assign in_tready = (st_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign last_tok  = tok[HOLES];

  assign rem_after = prem[HOLES] - size_r;
  assign pidx_ext  = 32'(pidx[HOLES]);
  assign rem_ext   = 32'(rem_after);

  always_comb begin
    ctrl.load    = accept && (in_op == OP_LOAD) && sel_ok;
    ctrl.restart = accept && (in_op == OP_RESTART);
    ctrl.commit  = (st_r == ST_SCAN) && last_tok && found[HOLES];
    ctrl.mode    = mode_r;
  end

  // load addresses by the item, commit by the winning candidate
  assign sel_bus  = ctrl.commit ? pidx[HOLES] : sel_ext[IW-1:0];
  assign size_bus = ctrl.load ? in_size : size_r;

  assign tok[0]   = start_r;
  assign found[0] = 1'b0;
  assign pidx[0]  = '0;
  assign prem[0]  = '0;

  for (genvar g = 0; g < HOLES; g++) begin : g_cell
    fma_cell #(
      .IDX        (g),
      .IW         (IW),
      .SIZE_WIDTH (SIZE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .hole_count (count_r),
      .sel_idx    (sel_bus),
      .size       (size_bus),
      .tok_i      (tok[g]),
      .found_i    (found[g]),
      .pidx_i     (pidx[g]),
      .prem_i     (prem[g]),
      .tok_o      (tok[g+1]),
      .found_o    (found[g+1]),
      .pidx_o     (pidx[g+1]),
      .prem_o     (prem[g+1])
    );
  end

  always_comb begin
    st_nxt      = st_r;
    size_nxt    = size_r;
    start_nxt   = 1'b0;
    res_gr_nxt  = res_gr_r;
    res_idx_nxt = res_idx_r;
    res_rem_nxt = res_rem_r;
    ov_nxt      = ov_r;
    og_nxt      = og_r;
    oidx_nxt    = oidx_r;
    orem_nxt    = orem_r;
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end
    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          res_gr_nxt  = 1'b0;
          res_idx_nxt = '0;
          res_rem_nxt = '0;
          size_nxt    = in_size;
          if (in_op == OP_REQUEST) begin
            start_nxt = 1'b1;
            st_nxt    = ST_SCAN;
          end else begin
            st_nxt = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (last_tok) begin
          if (found[HOLES]) begin
            res_gr_nxt  = 1'b1;
            res_idx_nxt = pidx_ext[IDX_OUT_W-1:0];
            res_rem_nxt = rem_ext[REM_OUT_W-1:0];
          end
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!ov_r || out_tready) begin
          ov_nxt   = 1'b1;
          og_nxt   = res_gr_r;
          oidx_nxt = res_idx_r;
          orem_nxt = res_rem_r;
          st_nxt   = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      start_r <= 1'b0;
      ov_r    <= 1'b0;
      mode_r  <= MODE_FIRST;
      count_r <= '0;
    end else begin
      st_r    <= st_nxt;
      start_r <= start_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_FIT_MODE:   mode_r  <= cfg_wdata[MODE_W-1:0];
          REG_HOLE_COUNT: count_r <= cfg_wdata[COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    size_r    <= size_nxt;
    res_gr_r  <= res_gr_nxt;
    res_idx_r <= res_idx_nxt;
    res_rem_r <= res_rem_nxt;
    og_r      <= og_nxt;
    oidx_r    <= oidx_nxt;
    orem_r    <= orem_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {4'b0, orem_r, oidx_r};
  assign out_tuser  = og_r;

endmodule
